@@ hw/rtl/rc5_block_cipher_defines.svh @@
// assertion macros for the rc5 block cipher rtl, used by rc5_ctrl
`ifndef RC5_BLOCK_CIPHER_DEFINES_SVH
`define RC5_BLOCK_CIPHER_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define RC5_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define RC5_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rc5_pkg.sv @@
`timescale 1ns / 1ps

package rc5_pkg;

    localparam int MAX_ROUNDS    = 32;
    localparam int MAX_KEY_WORDS = 8;
    localparam int TABLE_DEPTH   = 2 * MAX_ROUNDS + 2;
    localparam int SUBKEY_AW     = $clog2(TABLE_DEPTH);
    localparam int WORD_W        = 32;
    localparam int KEY_BYTES     = 4 * MAX_KEY_WORDS;
    localparam int KEY_BITS      = 8 * KEY_BYTES;
    localparam int KEY_IDX_W     = $clog2(MAX_KEY_WORDS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [WORD_W-1:0] MAGIC_P = 32'hB7E15163;
    localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9E3779B9;

    localparam logic [3:0] ROUNDS_Q_MIN = 4'd2;
    localparam logic [3:0] ROUNDS_Q_MAX = 4'(MAX_ROUNDS / 4);
    localparam logic [5:0] KEY_LEN_MAX  = 6'(KEY_BYTES);
    localparam logic [1:0] MIX_PASS_LAST = 2'd2;

    // operation codes carried in s_tuser
    localparam logic [1:0] OP_EXPAND  = 2'd0;
    localparam logic [1:0] OP_ENCRYPT = 2'd1;
    localparam logic [1:0] OP_DECRYPT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROUNDS_DIV4 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MODE_EXPAND,
        MODE_ENCRYPT,
        MODE_DECRYPT
    } mode_t;

    typedef struct packed {
        logic                 start_expand;
        logic                 start_block;
        logic                 rd_en;
        logic [SUBKEY_AW-1:0] rd_addr;
        logic                 exec_valid;
        mode_t                exec_mode;
        logic [SUBKEY_AW-1:0] exec_idx;
        logic                 exec_first;
        logic                 out_load;
        logic                 out_zero;
        logic                 out_status;
    } ctrl_cmd_t;

endpackage

@@ hw/rtl/rc5_block_cipher.sv @@
`timescale 1ns / 1ps
// channel   direction  tdata                 tuser
// s_        in         data_in[63:0]         op[1:0]
// m_        out        data_out[63:0]        status[0]
// cfg_      in         write data[63:0]      -  (index 0..5, no read-back)
//
// encrypt or decrypt: one subkey ram read per cycle
// key expansion: one mixing step per cycle on the subkey ram
// block before any expansion, or op 3: zero data
// reset: synchronous on aresetn low, key marked not valid, control and config registers to defaults
// a stalled m_ side holds the result; the next transaction is taken once it is loaded

module rc5_block_cipher (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // data_in[63:0]
    input  logic [1:0]                    s_tuser,   // op[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,   // data_out[63:0]
    output logic                          m_tuser,   // status[0]
    input  logic                          cfg_wr_en,
    input  logic [rc5_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rc5_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    logic [3:0]  rounds_reg;
    logic [5:0]  key_len_reg;
    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg;

    rc5_pkg::ctrl_cmd_t cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rounds_reg  <= 4'd3;
            key_len_reg <= 6'd16;
            key0_reg    <= '0;
            key1_reg    <= '0;
            key2_reg    <= '0;
            key3_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rc5_pkg::REG_ROUNDS_DIV4: rounds_reg  <= cfg_wr_data[3:0];
                rc5_pkg::REG_KEY_LENGTH:  key_len_reg <= cfg_wr_data[5:0];
                rc5_pkg::REG_KEY_WORD_0:  key0_reg    <= cfg_wr_data;
                rc5_pkg::REG_KEY_WORD_1:  key1_reg    <= cfg_wr_data;
                rc5_pkg::REG_KEY_WORD_2:  key2_reg    <= cfg_wr_data;
                rc5_pkg::REG_KEY_WORD_3:  key3_reg    <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    rc5_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_op        (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .rounds_div4 (rounds_reg),
        .cmd         (cmd)
    );

    rc5_datapath u_datapath (
        .aclk       (aclk),
        .cmd        (cmd),
        .s_tdata    (s_tdata),
        .key_length (key_len_reg),
        .key_bits   ({key3_reg, key2_reg, key1_reg, key0_reg}),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

@@ hw/rtl/rc5_ram.sv @@
`timescale 1ns / 1ps

module rc5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 66,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/rc5_ctrl.sv @@
`timescale 1ns / 1ps
`include "rc5_block_cipher_defines.svh"

module rc5_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         s_op,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  logic [3:0]         rounds_div4,
    output rc5_pkg::ctrl_cmd_t cmd
);

    rc5_pkg::state_t state_reg, state_next;
    rc5_pkg::mode_t  mode_reg, mode_next;
    logic [rc5_pkg::SUBKEY_AW-1:0] idx_reg, idx_next;
    logic [1:0] pass_reg, pass_next;
    logic key_valid_reg, key_valid_next;
    logic zero_reg, zero_next;
    logic status_reg, status_next;
    logic out_valid_reg, out_valid_next;
    logic exec_valid_reg, exec_valid_next;
    logic [rc5_pkg::SUBKEY_AW-1:0] exec_idx_reg, exec_idx_next;
    logic exec_first_reg, exec_first_next;

    logic [3:0] q_eff;
    logic [rc5_pkg::SUBKEY_AW-1:0] t_last;
    logic run_last;

    // index of the last subkey, 2R+1
    always_comb begin
        if (rounds_div4 < rc5_pkg::ROUNDS_Q_MIN) begin
            q_eff = rc5_pkg::ROUNDS_Q_MIN;
        end else if (rounds_div4 > rc5_pkg::ROUNDS_Q_MAX) begin
            q_eff = rc5_pkg::ROUNDS_Q_MAX;
        end else begin
            q_eff = rounds_div4;
        end
        t_last = {q_eff, 3'b001};
    end

    always_comb begin
        unique case (mode_reg)
            rc5_pkg::MODE_EXPAND: begin
                run_last = (pass_reg == rc5_pkg::MIX_PASS_LAST) && (idx_reg == t_last);
            end
            rc5_pkg::MODE_ENCRYPT: begin
                run_last = (idx_reg == t_last);
            end
            default: begin
                run_last = (idx_reg == '0);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rc5_pkg::ST_IDLE;
            mode_reg       <= rc5_pkg::MODE_EXPAND;
            idx_reg        <= '0;
            pass_reg       <= '0;
            key_valid_reg  <= 1'b0;
            zero_reg       <= 1'b0;
            status_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            exec_valid_reg <= 1'b0;
            exec_idx_reg   <= '0;
            exec_first_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            idx_reg        <= idx_next;
            pass_reg       <= pass_next;
            key_valid_reg  <= key_valid_next;
            zero_reg       <= zero_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
            exec_valid_reg <= exec_valid_next;
            exec_idx_reg   <= exec_idx_next;
            exec_first_reg <= exec_first_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        idx_next        = idx_reg;
        pass_next       = pass_reg;
        key_valid_next  = key_valid_reg;
        zero_next       = zero_reg;
        status_next     = status_reg;
        exec_valid_next = 1'b0;
        exec_idx_next   = idx_reg;
        exec_first_next = (pass_reg == 2'd0);
        s_tready        = 1'b0;

        cmd            = '0;
        cmd.rd_addr    = idx_reg;
        cmd.exec_valid = exec_valid_reg;
        cmd.exec_mode  = mode_reg;
        cmd.exec_idx   = exec_idx_reg;
        cmd.exec_first = exec_first_reg;
        cmd.out_zero   = zero_reg;
        cmd.out_status = status_reg;

        unique case (state_reg)
            rc5_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_op == rc5_pkg::OP_EXPAND) begin
                        mode_next        = rc5_pkg::MODE_EXPAND;
                        idx_next         = '0;
                        pass_next        = '0;
                        cmd.start_expand = 1'b1;
                        state_next       = rc5_pkg::ST_RUN;
                    end else if (s_op == rc5_pkg::OP_ENCRYPT && key_valid_reg) begin
                        mode_next       = rc5_pkg::MODE_ENCRYPT;
                        idx_next        = '0;
                        cmd.start_block = 1'b1;
                        state_next      = rc5_pkg::ST_RUN;
                    end else if (s_op == rc5_pkg::OP_DECRYPT && key_valid_reg) begin
                        mode_next       = rc5_pkg::MODE_DECRYPT;
                        idx_next        = t_last;
                        cmd.start_block = 1'b1;
                        state_next      = rc5_pkg::ST_RUN;
                    end else begin
                        zero_next   = 1'b1;
                        status_next = (s_op == rc5_pkg::OP_ENCRYPT)
                                   || (s_op == rc5_pkg::OP_DECRYPT);
                        state_next  = rc5_pkg::ST_FINISH;
                    end
                end
            end
            rc5_pkg::ST_RUN: begin
                cmd.rd_en       = 1'b1;
                exec_valid_next = 1'b1;
                unique case (mode_reg)
                    rc5_pkg::MODE_EXPAND: begin
                        if (idx_reg == t_last) begin
                            idx_next  = '0;
                            pass_next = pass_reg + 2'd1;
                        end else begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    rc5_pkg::MODE_ENCRYPT: begin
                        idx_next = idx_reg + 1'b1;
                    end
                    default: begin
                        idx_next = idx_reg - 1'b1;
                    end
                endcase
                if (run_last) begin
                    state_next = rc5_pkg::ST_DRAIN;
                end
            end
            rc5_pkg::ST_DRAIN: begin
                status_next = 1'b0;
                if (mode_reg == rc5_pkg::MODE_EXPAND) begin
                    key_valid_next = 1'b1;
                    zero_next      = 1'b1;
                end else begin
                    zero_next = 1'b0;
                end
                state_next = rc5_pkg::ST_FINISH;
            end
            rc5_pkg::ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = rc5_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rc5_pkg::ST_IDLE;
            end
        endcase

        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    `RC5_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_reg || m_tready, "pending result overwritten")
    `RC5_ASSERT_IMP(a_drain_has_step, state_reg == rc5_pkg::ST_DRAIN, exec_valid_reg, "drain without last step")
    `RC5_ASSERT_NXT(a_expand_sets_key, state_reg == rc5_pkg::ST_DRAIN && mode_reg == rc5_pkg::MODE_EXPAND, key_valid_reg, "key not marked valid")
    `RC5_ASSERT_NXT(a_accept_starts, s_tvalid && s_tready, state_reg == rc5_pkg::ST_RUN || state_reg == rc5_pkg::ST_FINISH, "accepted transaction did not start")

endmodule

@@ hw/rtl/rc5_datapath.sv @@
`timescale 1ns / 1ps

module rc5_datapath (
    input  logic                          aclk,
    input  rc5_pkg::ctrl_cmd_t            cmd,
    input  logic [63:0]                   s_tdata,
    input  logic [5:0]                    key_length,
    input  logic [rc5_pkg::KEY_BITS-1:0]  key_bits,
    output logic [63:0]                   m_tdata,
    output logic                          m_tuser
);

    localparam int W = rc5_pkg::WORD_W;

    function automatic logic [W-1:0] rotl(input logic [W-1:0] x, input logic [4:0] n);
        logic [2*W-1:0] d;
        d = {x, x} << n;
        return d[2*W-1:W];
    endfunction

    function automatic logic [W-1:0] rotr(input logic [W-1:0] x, input logic [4:0] n);
        logic [2*W-1:0] d;
        d = {x, x} >> n;
        return d[W-1:0];
    endfunction

    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] gen_reg, gen_next;
    logic [rc5_pkg::KEY_IDX_W-1:0] ki_reg, ki_next;
    logic [W-1:0] l_reg  [0:rc5_pkg::MAX_KEY_WORDS-1];
    logic [W-1:0] l_next [0:rc5_pkg::MAX_KEY_WORDS-1];
    logic [63:0] out_data_reg;
    logic        out_status_reg;

    logic [5:0] len_eff;
    logic [rc5_pkg::KEY_IDX_W-1:0] c_last;
    logic [rc5_pkg::KEY_BITS-1:0] key_masked;

    logic [W-1:0] rd_data;
    logic         ram_we;
    logic [W-1:0] s_val, sum1, a_mix, ab, b_mix;
    logic [W-1:0] a_enc, b_enc, a_dec, b_dec;
    logic         is_white;

    rc5_ram #(
        .WIDTH (W),
        .DEPTH (rc5_pkg::TABLE_DEPTH)
    ) u_subkeys (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cmd.exec_idx),
        .wdata (a_mix),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (rd_data)
    );

    always_comb begin
        if (key_length == 6'd0) begin
            len_eff = 6'd1;
        end else if (key_length > rc5_pkg::KEY_LEN_MAX) begin
            len_eff = rc5_pkg::KEY_LEN_MAX;
        end else begin
            len_eff = key_length;
        end
        c_last = rc5_pkg::KEY_IDX_W'(((7'(len_eff) + 7'd3) >> 2) - 7'd1);
        for (int i = 0; i < rc5_pkg::KEY_BYTES; i++) begin
            key_masked[8*i +: 8] = (6'(i) < len_eff) ? key_bits[8*i +: 8] : 8'h00;
        end
    end

    // one step of the selected mode per cycle
    always_comb begin
        s_val    = cmd.exec_first ? gen_reg : rd_data;
        sum1     = s_val + a_reg + b_reg;
        a_mix    = rotl(sum1, 5'd3);
        ab       = a_mix + b_reg;
        b_mix    = rotl(l_reg[ki_reg] + ab, ab[4:0]);
        a_enc    = rotl(a_reg ^ b_reg, b_reg[4:0]) + rd_data;
        b_enc    = rotl(b_reg ^ a_reg, a_reg[4:0]) + rd_data;
        b_dec    = rotr(b_reg - rd_data, a_reg[4:0]) ^ a_reg;
        a_dec    = rotr(a_reg - rd_data, b_reg[4:0]) ^ b_reg;
        is_white = (cmd.exec_idx[rc5_pkg::SUBKEY_AW-1:1] == '0);

        a_next   = a_reg;
        b_next   = b_reg;
        gen_next = gen_reg;
        ki_next  = ki_reg;
        ram_we   = 1'b0;
        for (int w = 0; w < rc5_pkg::MAX_KEY_WORDS; w++) begin
            l_next[w] = l_reg[w];
        end

        if (cmd.start_expand) begin
            a_next   = '0;
            b_next   = '0;
            gen_next = rc5_pkg::MAGIC_P;
            ki_next  = '0;
            for (int w = 0; w < rc5_pkg::MAX_KEY_WORDS; w++) begin
                l_next[w] = key_masked[W*w +: W];
            end
        end else if (cmd.start_block) begin
            a_next = s_tdata[W-1:0];
            b_next = s_tdata[2*W-1:W];
        end else if (cmd.exec_valid) begin
            unique case (cmd.exec_mode)
                rc5_pkg::MODE_EXPAND: begin
                    ram_we         = 1'b1;
                    a_next         = a_mix;
                    b_next         = b_mix;
                    l_next[ki_reg] = b_mix;
                    ki_next        = (ki_reg == c_last) ? '0 : ki_reg + 1'b1;
                    if (cmd.exec_first) begin
                        gen_next = gen_reg + rc5_pkg::MAGIC_Q;
                    end
                end
                rc5_pkg::MODE_ENCRYPT: begin
                    if (is_white) begin
                        if (cmd.exec_idx[0]) begin
                            b_next = b_reg + rd_data;
                        end else begin
                            a_next = a_reg + rd_data;
                        end
                    end else if (cmd.exec_idx[0]) begin
                        b_next = b_enc;
                    end else begin
                        a_next = a_enc;
                    end
                end
                rc5_pkg::MODE_DECRYPT: begin
                    if (is_white) begin
                        if (cmd.exec_idx[0]) begin
                            b_next = b_reg - rd_data;
                        end else begin
                            a_next = a_reg - rd_data;
                        end
                    end else if (cmd.exec_idx[0]) begin
                        b_next = b_dec;
                    end else begin
                        a_next = a_dec;
                    end
                end
                default: begin
                    a_next = a_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        gen_reg <= gen_next;
        ki_reg  <= ki_next;
        for (int w = 0; w < rc5_pkg::MAX_KEY_WORDS; w++) begin
            l_reg[w] <= l_next[w];
        end
        if (cmd.out_load) begin
            out_data_reg   <= cmd.out_zero ? 64'd0 : {b_reg, a_reg};
            out_status_reg <= cmd.out_status;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_status_reg;

endmodule
